@@ hdl/hkc_pkg.sv @@
package hkc_pkg;

  localparam logic [63:0] FnvBasis = 64'hCBF29CE484222325;

  // 32 key bytes then 12 iv bytes
  localparam logic [5:0] LastHashStep = 6'd43;

  typedef enum logic [2:0] {
    CFG_KEY_WORD_0 = 3'd0,
    CFG_KEY_WORD_1 = 3'd1,
    CFG_KEY_WORD_2 = 3'd2,
    CFG_KEY_WORD_3 = 3'd3,
    CFG_IV_LOW     = 3'd4,
    CFG_IV_HIGH    = 3'd5
  } cfg_reg_e;

  // one classified beat waiting for the keystream engine
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [2:0]  pos;
    logic        need_block;
    logic [63:0] block_index;
  } item_t;

  // multiply by the fnv prime 2^40 + 0x1b3, mod 2^64
  function automatic logic [63:0] fnv_mul(input logic [63:0] h);
    fnv_mul = (h << 40) + (h << 8) + (h << 7) + (h << 5) + (h << 4) + (h << 1) + h;
  endfunction

endpackage

@@ hdl/hkc_front.sv @@
module hkc_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [7:0]     data_byte_i,
  input  logic           first_byte_i,
  input  logic           last_byte_i,
  input  logic           push_ready_i,
  output logic           push_o,
  output hkc_pkg::item_t push_data_o
);
  import hkc_pkg::*;

  logic [63:0] block_counter_q, block_counter_d;
  logic [2:0]  byte_position_q, byte_position_d;
  logic [2:0]  pos;
  logic [63:0] blk;

  assign in_ready_o = push_ready_i;
  assign push_o     = in_valid_i && push_ready_i;

  // first flag restarts the stream at block 0, byte 0
  assign pos = first_byte_i ? 3'd0 : byte_position_q;
  assign blk = first_byte_i ? 64'd0 : block_counter_q;

  always_comb begin
    push_data_o.data        = data_byte_i;
    push_data_o.last        = last_byte_i;
    push_data_o.pos         = pos;
    push_data_o.need_block  = (pos == 3'd0);
    push_data_o.block_index = blk;
    block_counter_d = block_counter_q;
    byte_position_d = byte_position_q;
    if (push_o) begin
      block_counter_d = (pos == 3'd0) ? blk + 64'd1 : blk;
      byte_position_d = pos + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_counter_q <= '0;
      byte_position_q <= '0;
    end else begin
      block_counter_q <= block_counter_d;
      byte_position_q <= byte_position_d;
    end
  end

endmodule

@@ hdl/hkc_fifo.sv @@
module hkc_fifo #(
  parameter int Depth = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  hkc_pkg::item_t push_data_i,
  output logic           push_ready_o,
  input  logic           pop_i,
  output logic           head_valid_o,
  output hkc_pkg::item_t head_o
);
  import hkc_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;

  assign push_ready_o = (count_q != FullCnt);
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (!do_push && pop_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("queue popped while empty");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("queue count beyond depth");
  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !pop_i) |=> count_q == $past(count_q) + CntW'(1))
    else $error("queue count did not follow push");
`endif

endmodule

@@ hdl/hkc_back.sv @@
module hkc_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [2:0]     cfg_index_i,
  input  logic [63:0]    cfg_value_i,
  input  logic           head_valid_i,
  input  hkc_pkg::item_t head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_byte_o,
  output logic           out_last_o
);
  import hkc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HASH,
    ST_EMIT
  } state_e;

  state_e      state_q, state_d;
  logic [63:0] h_q, h_d;
  logic [5:0]  step_q, step_d;
  logic [63:0] ks_q, ks_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q, out_byte_d;
  logic        out_last_q, out_last_d;

  logic [63:0] key_word_0_q, key_word_1_q, key_word_2_q, key_word_3_q, iv_low_q;
  logic [31:0] iv_high_q;

  logic [63:0] src_word;
  logic [7:0]  absorb_byte;
  logic [63:0] h_next;
  logic        slot_free;
  logic [7:0]  emit_byte;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_word_0_q <= '0;
      key_word_1_q <= '0;
      key_word_2_q <= '0;
      key_word_3_q <= '0;
      iv_low_q     <= '0;
      iv_high_q    <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_KEY_WORD_0: key_word_0_q <= cfg_value_i;
        CFG_KEY_WORD_1: key_word_1_q <= cfg_value_i;
        CFG_KEY_WORD_2: key_word_2_q <= cfg_value_i;
        CFG_KEY_WORD_3: key_word_3_q <= cfg_value_i;
        CFG_IV_LOW:     iv_low_q     <= cfg_value_i;
        CFG_IV_HIGH:    iv_high_q    <= cfg_value_i[31:0];
        default: ;
      endcase
    end
  end

  // step counter walks key bytes then iv bytes, in register order
  always_comb begin
    case (cfg_reg_e'(step_q[5:3]))
      CFG_KEY_WORD_0: src_word = key_word_0_q;
      CFG_KEY_WORD_1: src_word = key_word_1_q;
      CFG_KEY_WORD_2: src_word = key_word_2_q;
      CFG_KEY_WORD_3: src_word = key_word_3_q;
      CFG_IV_LOW:     src_word = iv_low_q;
      CFG_IV_HIGH:    src_word = {32'd0, iv_high_q};
      default:        src_word = '0;
    endcase
  end

  assign absorb_byte = src_word[{step_q[2:0], 3'b000} +: 8];
  assign h_next      = fnv_mul(h_q ^ {56'd0, absorb_byte});
  assign slot_free   = !out_valid_q || out_ready_i;
  assign emit_byte   = head_i.data ^ ks_q[{head_i.pos, 3'b000} +: 8];

  always_comb begin
    state_d     = state_q;
    h_d         = h_q;
    step_d      = step_q;
    ks_d        = ks_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    pop_o       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (head_valid_i) begin
          if (head_i.need_block) begin
            h_d     = FnvBasis ^ head_i.block_index;
            step_d  = '0;
            state_d = ST_HASH;
          end else if (slot_free) begin
            out_valid_d = 1'b1;
            out_byte_d  = emit_byte;
            out_last_d  = head_i.last;
            pop_o       = 1'b1;
          end
        end
      end
      ST_HASH: begin
        h_d    = h_next;
        step_d = step_q + 6'd1;
        if (step_q == LastHashStep) begin
          ks_d    = h_next;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = emit_byte;
          out_last_d  = head_i.last;
          pop_o       = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      h_q         <= '0;
      step_q      <= '0;
      ks_q        <= '0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      h_q         <= h_d;
      step_q      <= step_d;
      ks_q        <= ks_d;
      out_valid_q <= out_valid_d;
      out_byte_q  <= out_byte_d;
      out_last_q  <= out_last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

`ifndef NO_ASSERTIONS
  a_head_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HASH || state_q == ST_EMIT) |-> head_valid_i)
    else $error("queue head lost during block generation");
  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_HASH |-> step_q <= LastHashStep)
    else $error("hash step beyond last absorbed byte");
  a_hash_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HASH && step_q == LastHashStep) |=> state_q == ST_EMIT)
    else $error("hash did not finish after last byte");
  a_pop_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> out_valid_q)
    else $error("beat popped without output");
`endif

endmodule

@@ hdl/hash_counter_keystream_cipher.sv @@
// a beat that opens an 8-byte keystream block waits in the queue, then the back engine seeds
// the hash with the block index, runs the 44-step hash loop and emits the byte; other beats pass
// to the output register when the engine is free; the hash loop does one fnv multiply per cycle,
// and the queue keeps taking bytes while a block is hashed, until it is full
// reset: block counter, byte position and all key and iv registers clear, queue empties
module hash_counter_keystream_cipher #(
  parameter int QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_value_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        out_last_o
);
  import hkc_pkg::*;

  logic  push;
  logic  push_ready;
  item_t push_data;
  logic  head_valid;
  item_t head;
  logic  pop;

  hkc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .first_byte_i (first_byte_i),
    .last_byte_i  (last_byte_i),
    .push_ready_i (push_ready),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  hkc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  hkc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_value_i  (cfg_value_i),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .out_last_o   (out_last_o)
  );

endmodule
